// ===== rtl/blr_pkg.sv =====
package blr_pkg;

	// Coordinate width of every endpoint and pixel coordinate field.
	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 32;

	// Command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	typedef struct packed {
		logic   command;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
		color_t line_color;
	} cmd_beat_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		color_t pixel_color;
		logic   last_pixel;
	} pix_beat_t;

endpackage

// ===== rtl/blr_engine.sv =====
module blr_engine import blr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid_s1,
	input  cmd_beat_t cmd_s1,
	output logic      push,
	output pix_beat_t push_beat
);

	localparam int DW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;

	logic                 busy_q;
	logic                 steep_q;
	coord_t               cursor_x_q;
	coord_t               cursor_y_q;
	coord_t               major_stop_q;
	logic                 minor_down_q;
	logic [DW-1:0]        major_delta_q;
	logic [DW-1:0]        minor_delta_q;
	logic signed [EW-1:0] error_q;
	color_t               color_q;

	logic signed [DW-1:0] diff_x, diff_y;
	logic [DW-1:0]        adx, ady;
	logic                 steep_new, swap;
	coord_t               p0_x, p0_y, p1_x, p1_y;
	logic [DW-1:0]        maj_new;

	logic                 is_start, is_step, last;
	logic signed [EW-1:0] err_add, err_sub;
	logic                 minor_move;
	coord_t               minor_inc;

	// Start: absolute deltas, major axis choice and endpoint ordering.
	always_comb begin
		diff_x = {cmd_s1.x_end[COORD_BITS-1], cmd_s1.x_end}
			- {cmd_s1.x_start[COORD_BITS-1], cmd_s1.x_start};
		diff_y = {cmd_s1.y_end[COORD_BITS-1], cmd_s1.y_end}
			- {cmd_s1.y_start[COORD_BITS-1], cmd_s1.y_start};
		adx = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
		ady = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
		steep_new = adx < ady;
		swap = steep_new ? (cmd_s1.y_start > cmd_s1.y_end) : (cmd_s1.x_start > cmd_s1.x_end);
		p0_x = swap ? cmd_s1.x_end : cmd_s1.x_start;
		p0_y = swap ? cmd_s1.y_end : cmd_s1.y_start;
		p1_x = swap ? cmd_s1.x_start : cmd_s1.x_end;
		p1_y = swap ? cmd_s1.y_start : cmd_s1.y_end;
		maj_new = steep_new ? ady : adx;
	end

	// Step: emit the cursor, then advance along the major axis.
	always_comb begin
		is_start = cmd_valid_s1 && (cmd_s1.command == CMD_START);
		is_step  = cmd_valid_s1 && (cmd_s1.command == CMD_STEP) && busy_q;
		last = (steep_q ? cursor_y_q : cursor_x_q) == major_stop_q;
		err_add = error_q + $signed({1'b0, minor_delta_q, 1'b0});
		err_sub = err_add - $signed({1'b0, major_delta_q, 1'b0});
		minor_move = err_add > 0;
		minor_inc = minor_down_q ? coord_t'(-1) : coord_t'(1);

		push = is_step;
		push_beat.pixel_x     = cursor_x_q;
		push_beat.pixel_y     = cursor_y_q;
		push_beat.pixel_color = color_q;
		push_beat.last_pixel  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			steep_q       <= 1'b0;
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			major_stop_q  <= '0;
			minor_down_q  <= 1'b0;
			major_delta_q <= '0;
			minor_delta_q <= '0;
			error_q       <= '0;
			color_q       <= '0;
		end else if (is_start) begin
			busy_q        <= 1'b1;
			steep_q       <= steep_new;
			cursor_x_q    <= p0_x;
			cursor_y_q    <= p0_y;
			major_stop_q  <= steep_new ? p1_y : p1_x;
			minor_down_q  <= steep_new ? (p1_x < p0_x) : (p1_y < p0_y);
			major_delta_q <= maj_new;
			minor_delta_q <= steep_new ? adx : ady;
			error_q       <= -$signed({2'b00, maj_new});
			color_q       <= cmd_s1.line_color;
		end else if (is_step) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				error_q <= minor_move ? err_sub : err_add;
				if (steep_q) begin
					cursor_y_q <= cursor_y_q + coord_t'(1);
					if (minor_move) begin
						cursor_x_q <= cursor_x_q + minor_inc;
					end
				end else begin
					cursor_x_q <= cursor_x_q + coord_t'(1);
					if (minor_move) begin
						cursor_y_q <= cursor_y_q + minor_inc;
					end
				end
			end
		end
	end

	// The final pixel of a line ends it.
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(is_step && last) |=> !busy_q)
		else $error("line still active after its last pixel");

	// The error term stays at or below zero between steps.
	a_error_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (error_q <= 0))
		else $error("error term positive while a line is active");

	// A start always yields an active line and no pixel.
	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		is_start |=> (busy_q && !$past(push)))
		else $error("start did not load a line");

endmodule

// ===== rtl/blr_out_fifo.sv =====
module blr_out_fifo import blr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pix_beat_t push_beat,
	output logic [1:0] level,
	output logic      pix_valid,
	input  logic      pix_ready,
	output pix_beat_t pix
);

	localparam int DEPTH = 3;

	pix_beat_t  mem [DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q, level_q;
	logic       pop;

	assign pop       = pix_valid && pix_ready;
	assign pix_valid = level_q != 2'd0;
	assign pix       = mem[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (level_q == 2'(DEPTH))))
		else $error("pixel queue overflow");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= 2'(DEPTH))
		else $error("pixel queue level out of range");

	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (level_q == $past(level_q) + 2'd1))
		else $error("pixel queue level did not advance on push");

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer, all eight octants.
//
// The cmd channel takes one beat per command. A start beat loads two
// endpoints and a color and produces no pixel. A step beat produces one
// pixel of the active line on the pix channel; the final endpoint pixel
// carries last_pixel, after which the line is closed. A step beat with no
// active line is consumed and produces nothing. A start beat while a line
// is active drops that line.
//
// An accepted step beat is first registered in the command register;
// the Bresenham update then writes its pixel into a three-entry output
// queue, which drives pix. Throughput is one command per cycle while
// cmd_ready is high; a step adds, compares and subtracts the error term.
//
// When the receiver stalls, the queue absorbs the pixels still in flight
// and cmd_ready drops only once the queue plus the command register hold
// three beats, so no pixel is lost. Reset clears the queue and the
// command register and leaves no line active.
module bresenham_line_rasterizer import blr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_beat_t cmd,
	output logic      pix_valid,
	input  logic      pix_ready,
	output pix_beat_t pix
);

	localparam int QUEUE_DEPTH = 3;

	logic      cmd_valid_s1;
	cmd_beat_t cmd_s1;
	logic      push;
	pix_beat_t push_beat;
	logic [1:0] level;
	logic [2:0] credit_used;

	// Every beat in the command register may still need a queue slot, so
	// count it against the queue before taking another command.
	assign credit_used = {1'b0, level} + {2'b00, cmd_valid_s1};
	assign cmd_ready   = credit_used < 3'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else begin
			cmd_valid_s1 <= cmd_valid && cmd_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	blr_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid_s1 (cmd_valid_s1),
		.cmd_s1       (cmd_s1),
		.push         (push),
		.push_beat    (push_beat)
	);

	blr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.level     (level),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	// A pixel is only produced by a beat that sat in the command register.
	a_push_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cmd_valid_s1)
		else $error("pixel produced without a command");

	// The credit count never promises more slots than the queue has.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_used <= 3'(QUEUE_DEPTH))
		else $error("command credit exceeds queue depth");

	// A full queue with a stalled receiver blocks new commands.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(level == 2'(QUEUE_DEPTH)) |-> !cmd_ready)
		else $error("command accepted with a full pixel queue");

endmodule

// ===== dv/blr_pixel_checker.sv =====
`timescale 1ns / 100ps

module blr_pixel_checker import blr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  cmd_beat_t cmd,
	input  logic      pix_valid,
	input  logic      pix_ready,
	input  pix_beat_t pix,
	output int        mismatches,
	output int        pixels_due,
	output int        pixels_seen
);

	// Shadow copy of the line engine.
	logic               line_on;
	logic               y_major;
	coord_t             cur_x;
	coord_t             cur_y;
	coord_t             stop_major;
	logic               minor_neg;
	logic [12:0]        span_major;
	logic [12:0]        span_minor;
	logic signed [15:0] err_acc;
	color_t             line_hue;
	pix_beat_t          path_due[$];
	int                 seen_total;

	task automatic load_line(input cmd_beat_t b);
		int xa, ya, xb, yb, adx, ady, t;
		xa = b.x_start;
		ya = b.y_start;
		xb = b.x_end;
		yb = b.y_end;
		adx = (xb >= xa) ? xb - xa : xa - xb;
		ady = (yb >= ya) ? yb - ya : ya - yb;
		y_major = (adx < ady);
		if (!y_major) begin
			if (xa > xb) begin
				t = xa; xa = xb; xb = t;
				t = ya; ya = yb; yb = t;
			end
			minor_neg  = (yb < ya);
			stop_major = coord_t'(xb);
			span_major = 13'(adx);
			span_minor = 13'(ady);
			err_acc    = 16'(-adx);
		end else begin
			if (ya > yb) begin
				t = xa; xa = xb; xb = t;
				t = ya; ya = yb; yb = t;
			end
			minor_neg  = (xb < xa);
			stop_major = coord_t'(yb);
			span_major = 13'(ady);
			span_minor = 13'(adx);
			err_acc    = 16'(-ady);
		end
		cur_x    = coord_t'(xa);
		cur_y    = coord_t'(ya);
		line_hue = b.line_color;
		line_on  = 1'b1;
	endtask

	// One step: queue the pixel at the cursor, then advance along the major axis.
	task automatic step_line();
		pix_beat_t p;
		logic      at_end;
		if (!line_on)
			return;
		at_end = y_major ? (cur_y == stop_major) : (cur_x == stop_major);
		p.pixel_x     = cur_x;
		p.pixel_y     = cur_y;
		p.pixel_color = line_hue;
		p.last_pixel  = at_end;
		path_due.push_back(p);
		if (at_end) begin
			line_on = 1'b0;
			return;
		end
		err_acc = err_acc + $signed({2'b00, span_minor, 1'b0});
		if (err_acc > 0) begin
			if (y_major)
				cur_x = minor_neg ? coord_t'(cur_x - 1) : coord_t'(cur_x + 1);
			else
				cur_y = minor_neg ? coord_t'(cur_y - 1) : coord_t'(cur_y + 1);
			err_acc = err_acc - $signed({2'b00, span_major, 1'b0});
		end
		if (y_major)
			cur_y = coord_t'(cur_y + 1);
		else
			cur_x = coord_t'(cur_x + 1);
	endtask

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s mismatch on pixel %0d: expected %0h, got %0h",
			$time, field, seen_total, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pix_beat_t want;
		int        bad;
		if (!arst_n) begin
			line_on    = 1'b0;
			y_major    = 1'b0;
			cur_x      = '0;
			cur_y      = '0;
			stop_major = '0;
			minor_neg  = 1'b0;
			span_major = '0;
			span_minor = '0;
			err_acc    = '0;
			line_hue   = '0;
			seen_total = 0;
			path_due.delete();
			mismatches  <= 0;
			pixels_due  <= 0;
			pixels_seen <= 0;
		end else begin
			bad = 0;
			// A pixel leaves only once its step is registered and queued, so retire first.
			if (pix_valid && pix_ready) begin
				if (path_due.size() == 0) begin
					$display("%0t: expected no pixel, got x=%0d y=%0d color=%0h last=%0b",
						$time, pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel);
					bad++;
				end else begin
					want = path_due.pop_front();
					if (pix.pixel_x !== want.pixel_x) begin
						report_field("pixel_x", 32'(want.pixel_x), 32'(pix.pixel_x));
						bad++;
					end
					if (pix.pixel_y !== want.pixel_y) begin
						report_field("pixel_y", 32'(want.pixel_y), 32'(pix.pixel_y));
						bad++;
					end
					if (pix.pixel_color !== want.pixel_color) begin
						report_field("pixel_color", want.pixel_color, pix.pixel_color);
						bad++;
					end
					if (pix.last_pixel !== want.last_pixel) begin
						report_field("last_pixel", 32'(want.last_pixel), 32'(pix.last_pixel));
						bad++;
					end
				end
				seen_total++;
			end
			if (cmd_valid && cmd_ready) begin
				if (cmd.command == CMD_START)
					load_line(cmd);
				else
					step_line();
			end
			mismatches  <= mismatches + bad;
			pixels_due  <= path_due.size();
			pixels_seen <= seen_total;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb import blr_pkg::*; ();

	// Longest output hold-off, and how many cycles with no beat on either
	// channel are tolerated before the run is declared hung.
	localparam int HOLD_CYCLES = 96;
	localparam int QUIET_LIMIT = 4000;
	localparam int ITEM_TARGET = 1050;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_beat_t cmd;
	logic      pix_valid;
	logic      pix_ready;
	pix_beat_t pix;

	int mismatches;
	int pixels_due;
	int pixels_seen;

	// Sender bookkeeping; send_calm counts beats still to go with no gap.
	int starts_sent;
	int steps_sent;
	int send_calm;
	int quiet_cycles;
	// Raised by the stimulus to ask the pixel side for one long hold-off.
	bit stall_request;

	bresenham_line_rasterizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	// The checker sees both channels, runs its own copy of the line engine
	// and hands back the mismatch count and the number of pixels still owed.
	blr_pixel_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.mismatches  (mismatches),
		.pixels_due  (pixels_due),
		.pixels_seen (pixels_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hang detector: counts cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (pix_valid && pix_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no beat for %0d cycles at %0t, %0d pixels still owed",
					QUIET_LIMIT, $time, pixels_due);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Pixel side. Each beat is preceded by a random gap, with runs of
	// back-to-back acceptance mixed in. When the stimulus asks for it, ready
	// is held low for a long stretch so that the engine's queue fills and
	// it has to push back on the command side.
	initial begin : pixel_sink
		int gap;
		int calm;
		bit stall_taken;
		pix_ready = 1'b0;
		calm = 0;
		stall_taken = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (stall_request && !stall_taken) begin
				pix_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_taken = 1'b1;
			end else begin
				if (calm > 0) begin
					gap = 0;
					calm--;
				end else begin
					gap = $urandom_range(0, 11);
					if ($urandom_range(0, 15) == 0)
						calm = $urandom_range(10, 40);
				end
				if (gap > 0) begin
					pix_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pix_ready <= 1'b1;
			do @(posedge clk); while (!pix_valid);
		end
	end

	function automatic int rand_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int rand_delta(input int reach);
		return int'($urandom_range(0, 2 * reach)) - reach;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < -2048)
			return -2048;
		if (v > 2047)
			return 2047;
		return v;
	endfunction

	// Number of pixels a line between the two endpoints covers.
	function automatic int line_len(input int xa, ya, xb, yb);
		int adx, ady;
		adx = (xb >= xa) ? xb - xa : xa - xb;
		ady = (yb >= ya) ? yb - ya : ya - yb;
		return ((adx > ady) ? adx : ady) + 1;
	endfunction

	// A step beat ignores everything but the command bit, so the rest of
	// the payload is filled with noise to prove that.
	function automatic cmd_beat_t junk_step();
		cmd_beat_t b;
		b = cmd_beat_t'({$urandom(), $urandom(), $urandom()});
		b.command = CMD_STEP;
		return b;
	endfunction

	// Offers one command beat after a random gap and holds it until the
	// engine takes it. With a gap of zero valid simply stays high.
	task automatic send_cmd(input cmd_beat_t b);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = $urandom_range(0, 11);
			if ($urandom_range(0, 15) == 0)
				send_calm = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= b;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		if (b.command == CMD_START)
			starts_sent++;
		else
			steps_sent++;
	endtask

	// Starts a line and then issues the given number of steps. Fewer steps
	// than the line length leave it open for the next start to drop; more
	// steps than that land on an idle engine.
	task automatic run_line(input int xa, ya, xb, yb, input color_t hue,
			input int n_steps);
		cmd_beat_t b;
		b.command    = CMD_START;
		b.x_start    = coord_t'(xa);
		b.y_start    = coord_t'(ya);
		b.x_end      = coord_t'(xb);
		b.y_end      = coord_t'(yb);
		b.line_color = hue;
		send_cmd(b);
		repeat (n_steps) send_cmd(junk_step());
	endtask

	initial begin : stimulus
		int  xa, ya, xb, yb, len, kind, reach, d;
		bit  stall_done;
		bit  pause_done;
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		cmd           = '0;
		starts_sent   = 0;
		steps_sent    = 0;
		send_calm     = 0;
		stall_request = 1'b0;
		stall_done    = 1'b0;
		pause_done    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A step before any line exists must be swallowed.
		send_cmd(junk_step());
		// Single point line at the top corner: one pixel flagged last, and
		// the extra step after it again finds the engine idle.
		run_line(2047, 2047, 2047, 2047, '1, 2);
		// Full-width 45 degree line going down, dropped after three pixels.
		run_line(-2048, 2047, 2047, -2048, '0, 3);
		// Shallow line given right to left, so the endpoints get swapped.
		run_line(3, -1, -1, 1, 32'h5555_5555, 5);
		// Steep line given top down, swapped and drawn to its end.
		run_line(1, 2, 0, -1, 32'haaaa_aaaa, 4);
		// Corner to corner, dropped early by the next start.
		run_line(-2048, -2048, 2047, 2047, 32'h8000_0001, 2);
		// Steep line spanning the whole y range with a one pixel x drift.
		run_line(0, -2048, -1, 2047, $urandom(), 2);

		// Random part. Mostly short complete lines anywhere on the plane,
		// with long lines cut short, aborted lines, stray steps and pure
		// horizontal, vertical and diagonal shapes mixed in.
		while (starts_sent + steps_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (!stall_done && starts_sent + steps_sent > 300) begin
				// Back-to-back steps against a stalled pixel side: the queue
				// fills and the engine must hold off the command side.
				stall_done    = 1'b1;
				stall_request = 1'b1;
				send_calm     = 80;
				xa = int'($urandom_range(0, 3900)) - 2048;
				ya = int'($urandom_range(0, 4000)) - 2048;
				run_line(xa, ya, xa + 60, ya + int'($urandom_range(0, 30)),
					$urandom(), 61);
			end else if (!pause_done && starts_sent + steps_sent > 650) begin
				// Let the engine drain completely before going on.
				pause_done = 1'b1;
				cmd_valid <= 1'b0;
				do @(posedge clk); while (pixels_due != 0);
			end else if (kind < 68) begin
				reach = ($urandom_range(0, 7) == 0) ? 40 : 10;
				xa  = rand_coord();
				ya  = rand_coord();
				xb  = clamp_coord(xa + rand_delta(reach));
				yb  = clamp_coord(ya + rand_delta(reach));
				len = line_len(xa, ya, xb, yb);
				run_line(xa, ya, xb, yb, $urandom(),
					len + (($urandom_range(0, 3) == 0) ? 1 : 0));
			end else if (kind < 78) begin
				run_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					$urandom(), $urandom_range(0, 6));
			end else if (kind < 88) begin
				xa  = rand_coord();
				ya  = rand_coord();
				xb  = clamp_coord(xa + rand_delta(12));
				yb  = clamp_coord(ya + rand_delta(12));
				len = line_len(xa, ya, xb, yb);
				run_line(xa, ya, xb, yb, $urandom(), $urandom_range(0, len - 1));
			end else if (kind < 94) begin
				repeat ($urandom_range(1, 3)) send_cmd(junk_step());
			end else begin
				xa = rand_coord();
				ya = rand_coord();
				d  = rand_delta(15);
				case ($urandom_range(0, 2))
					0: begin
						xb = xa + d;
						yb = ya;
					end
					1: begin
						xb = xa;
						yb = ya + d;
					end
					default: begin
						xb = xa + d;
						yb = ($urandom_range(0, 1) == 0) ? ya + d : ya - d;
					end
				endcase
				xb = clamp_coord(xb);
				yb = clamp_coord(yb);
				run_line(xa, ya, xb, yb, $urandom(), line_len(xa, ya, xb, yb));
			end
		end

		// Drain: wait for every owed pixel, then keep the clock running so that
		// a stray extra pixel would still be caught by the checker.
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pixels_due != 0);
		repeat (24) @(posedge clk);

		$display("Sent %0d line starts and %0d step beats; %0d pixels were compared.",
			starts_sent, steps_sent, pixels_seen);
		$display("Lines of every octant, single points, restarts mid-line, idle steps, %s",
			"a long pixel stall and a full drain were exercised.");
		if (mismatches == 0 && pixels_due == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
